>>> rtl/core/segregated_free_list_allocator_assert.svh
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH
// checks sampled on clk, off during rst
`define SFLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SFLA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

>>> rtl/core/sfla_pkg.sv
`default_nettype none
package sfla_pkg;
  typedef struct packed {
    logic        cmd;
    logic [16:0] req_size;
    logic [15:0] block_addr;
  } sfla_in_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] result_addr;
  } sfla_out_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // push sources
  typedef enum logic [1:0] {
    PSRC_FREE,
    PSRC_CACHE,
    PSRC_LEFT
  } psrc_t;

  typedef struct packed {
    logic  latch_req;
    logic  push;
    psrc_t push_src;
    logic  pop_rd;
    logic  pop_fin;
    logic  cache_carve;
    logic  cache_clr;
    logic  bump;
    logic  set_res;
    logic  res_ok;
    logic  res_from_cache;
    logic  res_from_bump;
    logic  small_pop;
  } sfla_cmd_t;

  typedef struct packed {
    logic is_free;
    logic is_small;
    logic cache_ok;
    logic cache_flush;
    logic bump_ok;
    logic pop_found;
    logic has_left;
  } sfla_sts_t;
endpackage
`default_nettype wire

>>> rtl/core/sfla_ram.sv
`default_nettype none
module sfla_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/sfla_datapath.sv
`default_nettype none
module sfla_datapath #(
  parameter int HEAP_BYTES       = 65536,
  parameter int ALIGN_BYTES      = 16,
  parameter int SMALL_LIMIT_LOG2 = 8,
  parameter int SIZE_CLASSES     = 17
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [16:0]          cfg_data,
  input  wire sfla_pkg::sfla_in_t   req,
  input  wire sfla_pkg::sfla_cmd_t  ctl,
  output sfla_pkg::sfla_sts_t       sts,
  output sfla_pkg::sfla_out_t       res
);
  import sfla_pkg::*;

  localparam int ALG    = $clog2(ALIGN_BYTES);
  localparam int NODES  = HEAP_BYTES / ALIGN_BYTES;
  localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int KW     = $clog2(SIZE_CLASSES);
  localparam logic [16:0] SMALL_SZ = 17'(1 << SMALL_LIMIT_LOG2);
  localparam logic [16:0] SAT17 = 17'((131071 / ALIGN_BYTES) * ALIGN_BYTES);
  localparam logic [17:0] HEAP18 = (HEAP_BYTES > 131071) ? 18'h3FFFF : 18'(HEAP_BYTES);

  logic [16:0] heap_limit;
  logic [16:0] bump_pointer;
  logic [15:0] cache_addr;
  logic [16:0] cache_size;
  logic        cache_valid;
  logic [15:0] bin_head [SIZE_CLASSES];
  logic [SIZE_CLASSES-1:0] bin_nonempty;

  logic        cmd_r;
  logic [16:0] size_r;
  logic [17:0] a_r;
  logic [15:0] faddr_r;
  logic [KW-1:0] pk;
  logic [15:0] paddr;
  logic [16:0] psize;
  logic [KW-1:0] popk;
  logic        popf;
  logic [15:0] r_r;
  logic [16:0] left_r;
  logic        granted_r;
  logic [15:0] raddr_r;

  logic [16:0] link_q, bsize_q;
  logic [NW-1:0] widx, ridx;
  logic        wr_ok;

  logic [17:0] a_c;
  logic [17:0] lim;
  logic [18:0] bump_sum;
  logic [KW-1:0] search_start;
  logic [4:0] ceil_log;
  logic [17:0] szm1;
  logic [KW-1:0] found_k;
  logic        found;
  logic [17:0] push_sz;
  logic [4:0]  bl;

  assign a_c = ((18'(req.req_size) + 18'(ALIGN_BYTES - 1)) >> ALG) << ALG;
  assign lim = (18'(heap_limit) < HEAP18) ? 18'(heap_limit) : HEAP18;
  assign bump_sum = 19'(bump_pointer) + 19'(a_r);

  always_comb begin
    szm1 = 18'(size_r) - 18'd1;
    ceil_log = 5'd0;
    for (int i = 0; i < 18; i++) if (size_r > 17'd1 && szm1[i]) ceil_log = 5'(i + 1);
  end

  always_comb begin
    if (!sts.is_small) search_start = KW'(ceil_log + 5'd1);
    else search_start = KW'(SMALL_LIMIT_LOG2);
    found = 1'b0;
    found_k = '0;
    for (int k = SIZE_CLASSES - 1; k >= 0; k--) begin
      if (bin_nonempty[k] && (ceil_log + 5'd1 <= 5'(k) || sts.is_small)
          && 32'(k) >= 32'(search_start) && 32'(search_start) < SIZE_CLASSES) begin
        found = 1'b1;
        found_k = KW'(k);
      end
    end
  end

  always_comb begin
    unique case (ctl.push_src)
      PSRC_CACHE: begin
        paddr = cache_addr;
        push_sz = 18'(cache_size);
      end
      PSRC_LEFT: begin
        paddr = r_r + a_r[15:0];
        push_sz = 18'(left_r);
      end
      default: begin
        paddr = faddr_r;
        push_sz = (a_r > 18'h1FFFF) ? 18'(SAT17) : a_r;
      end
    endcase
    psize = push_sz[16:0];
    bl = 5'd0;
    for (int i = 0; i < 18; i++) if (push_sz + 18'd1 >> i != 18'd0) bl = 5'(i);
    pk = (32'(bl) >= SIZE_CLASSES) ? KW'(SIZE_CLASSES - 1) : KW'(bl);
  end

  assign widx  = NW'(paddr >> ALG);
  assign wr_ok = (32'(paddr >> ALG) < NODES);
  assign ridx  = NW'(bin_head[popk] >> ALG);

  sfla_ram #(.WIDTH(17), .DEPTH(NODES)) u_link (
    .clk, .we(ctl.push && wr_ok), .waddr(widx),
    .wdata({bin_nonempty[pk], bin_head[pk]}), .raddr(ridx), .rdata(link_q));
  sfla_ram #(.WIDTH(17), .DEPTH(NODES)) u_size (
    .clk, .we(ctl.push && wr_ok), .waddr(widx),
    .wdata(psize), .raddr(ridx), .rdata(bsize_q));

  logic        pidx_ok;
  logic [17:0] left_c;
  assign pidx_ok = (32'(bin_head[popk] >> ALG) < NODES);
  assign left_c = (18'(pidx_ok ? bsize_q : 17'd0) >= a_r)
                ? 18'(pidx_ok ? bsize_q : 17'd0) - a_r : 18'd0;

  assign sts.is_free     = cmd_r;
  assign sts.is_small    = (size_r <= SMALL_SZ);
  assign sts.cache_ok    = cache_valid && cache_size >= SMALL_SZ && 18'(cache_size) >= a_r;
  assign sts.cache_flush = cache_valid && cache_size != 17'd0;
  assign sts.bump_ok     = 19'(bump_sum) < 19'(lim);
  assign sts.pop_found   = popf;
  assign sts.has_left    = left_r != 17'd0;

  assign res.granted     = granted_r;
  assign res.result_addr = raddr_r;

  always_ff @(posedge clk) begin
    if (ctl.latch_req) begin
      cmd_r   <= req.cmd;
      size_r  <= req.req_size;
      a_r     <= a_c;
      faddr_r <= (req.block_addr >> ALG) << ALG;
    end
    if (ctl.pop_rd) begin
      popk <= found_k;
      popf <= found;
    end
    if (ctl.pop_fin) begin
      r_r    <= bin_head[popk];
      left_r <= left_c[16:0];
    end
    if (ctl.set_res) begin
      if (!ctl.res_ok || sts.is_free) raddr_r <= 16'd0;
      else if (ctl.res_from_cache) raddr_r <= cache_addr;
      else if (ctl.res_from_bump) raddr_r <= bump_pointer[15:0];
      else raddr_r <= r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit   <= 17'h10000;
      bump_pointer <= '0;
      cache_addr   <= '0;
      cache_size   <= '0;
      cache_valid  <= 1'b0;
      bin_nonempty <= '0;
      granted_r    <= 1'b0;
    end else begin
      if (cfg_we) heap_limit <= cfg_data;
      if (ctl.set_res) granted_r <= ctl.res_ok;
      if (ctl.bump) bump_pointer <= bump_sum[16:0];
      if (ctl.cache_carve) begin
        cache_addr <= cache_addr + a_r[15:0];
        cache_size <= cache_size - a_r[16:0];
      end
      if (ctl.cache_clr) begin
        cache_valid <= 1'b0;
        cache_size  <= '0;
        cache_addr  <= '0;
      end
      if (ctl.pop_fin) begin
        bin_head[popk]     <= pidx_ok ? link_q[15:0] : 16'd0;
        bin_nonempty[popk] <= pidx_ok && link_q[16];
        if (ctl.small_pop) begin
          cache_addr  <= bin_head[popk] + a_r[15:0];
          cache_size  <= left_c[16:0];
          cache_valid <= 1'b1;
        end
      end
      if (ctl.push && wr_ok) begin
        bin_head[pk]     <= paddr;
        bin_nonempty[pk] <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sfla_ctrl.sv
`default_nettype none
module sfla_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire sfla_pkg::sfla_sts_t sts,
  output sfla_pkg::sfla_cmd_t      ctl
);
  import sfla_pkg::*;
  `include "segregated_free_list_allocator_assert.svh"

  typedef enum logic [3:0] {
    IDLE, DECIDE, FLUSH, BUMP, POPSEL, POPRD, POPFIN, LEFTPUSH, DONE
  } state_t;

  state_t state, state_next;
  logic   busy;

  assign busy = (state != IDLE) || out_valid;
  assign in_stall = busy;

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        ctl.latch_req = in_valid && !busy;
        if (in_valid && !out_valid) state_next = DECIDE;
      end
      DECIDE: begin
        if (sts.is_free) begin
          ctl.push = 1'b1;
          ctl.push_src = PSRC_FREE;
          ctl.set_res = 1'b1;
          ctl.res_ok = 1'b1;
          ctl.res_from_cache = 1'b0;
          state_next = DONE;
        end else if (sts.is_small && sts.cache_ok) begin
          ctl.set_res = 1'b1;
          ctl.res_ok = 1'b1;
          ctl.res_from_cache = 1'b1;
          ctl.cache_carve = 1'b1;
          state_next = DONE;
        end else if (sts.is_small) begin
          state_next = FLUSH;
        end else begin
          state_next = BUMP;
        end
      end
      FLUSH: begin
        ctl.push = sts.cache_flush;
        ctl.push_src = PSRC_CACHE;
        ctl.cache_clr = 1'b1;
        state_next = sts.is_small ? BUMP : POPSEL;
      end
      BUMP: begin
        if (sts.bump_ok) begin
          ctl.set_res = 1'b1;
          ctl.res_ok = 1'b1;
          ctl.res_from_bump = 1'b1;
          ctl.bump = 1'b1;
          state_next = DONE;
        end else begin
          state_next = sts.is_small ? POPSEL : FLUSH;
        end
      end
      POPSEL: begin
        ctl.pop_rd = 1'b1;
        state_next = POPRD;
      end
      POPRD: begin
        if (sts.pop_found) state_next = POPFIN;
        else begin
          ctl.set_res = 1'b1;
          state_next = DONE;
        end
      end
      POPFIN: begin
        ctl.pop_fin = 1'b1;
        ctl.small_pop = sts.is_small;
        state_next = LEFTPUSH;
      end
      LEFTPUSH: begin
        ctl.push = !sts.is_small && sts.has_left;
        ctl.push_src = PSRC_LEFT;
        ctl.set_res = 1'b1;
        ctl.res_ok = 1'b1;
        state_next = DONE;
      end
      DONE: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == DONE) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `SFLA_ASSERT(a_no_accept_busy, !(in_valid && !in_stall && state != IDLE), "accept while busy")
  `SFLA_ASSERT_NEXT(a_done_valid, state == DONE, out_valid, "result lost")
  `SFLA_ASSERT(a_one_push_src, !(ctl.push && ctl.pop_fin), "push and pop together")
endmodule
`default_nettype wire

>>> rtl/core/segregated_free_list_allocator.sv
`default_nettype none
// Segregated-fit heap allocator with power-of-two free bins. A transaction
// (allocate or free) steps through a sequence of states: an allocation through
// cache check, bump, bin priority search and a registered read of the block
// link memory; a free pushes the block onto its bin. One transaction is in
// flight at a time and the next is taken the cycle after the result leaves.
// The result is held on out until taken. heap_limit is written through
// cfg_we/cfg_data; the user must write it only while idle (not enforced).
module segregated_free_list_allocator #(
  parameter int HEAP_BYTES       = 65536,
  parameter int ALIGN_BYTES      = 16,
  parameter int SMALL_LIMIT_LOG2 = 8,
  parameter int SIZE_CLASSES     = 17
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [16:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sfla_pkg::sfla_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sfla_pkg::sfla_out_t     out_data
);
  import sfla_pkg::*;

  sfla_cmd_t ctl;
  sfla_sts_t sts;

  sfla_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .ctl);

  sfla_datapath #(
    .HEAP_BYTES(HEAP_BYTES), .ALIGN_BYTES(ALIGN_BYTES),
    .SMALL_LIMIT_LOG2(SMALL_LIMIT_LOG2), .SIZE_CLASSES(SIZE_CLASSES)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .req(in_data), .ctl, .sts, .res(out_data));
endmodule
`default_nettype wire
